[hdl/scpf_pkg.sv]
// Shared types and constants of the servo command packet framer.
package scpf_pkg;

    localparam logic [1:0] OP_GOAL_POS = 2'd0;
    localparam logic [1:0] OP_TORQUE   = 2'd1;
    localparam logic [1:0] OP_READ_POS = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [2:0] REG_HEADER_VALUE     = 3'd0;
    localparam logic [2:0] REG_WRITE_INSTR      = 3'd1;
    localparam logic [2:0] REG_READ_INSTR       = 3'd2;
    localparam logic [2:0] REG_GOAL_POSITION    = 3'd3;
    localparam logic [2:0] REG_PRESENT_POSITION = 3'd4;
    localparam logic [2:0] REG_TORQUE_ENABLE    = 3'd5;
    localparam logic [2:0] REG_POSITION_LIMIT   = 3'd6;

    localparam int CFG_WIDTH = 15;

    localparam logic [3:0] IDX_HEADER0 = 4'd0;
    localparam logic [3:0] IDX_HEADER1 = 4'd1;
    localparam logic [3:0] IDX_ID      = 4'd2;
    localparam logic [3:0] IDX_LENGTH  = 4'd3;
    localparam logic [3:0] IDX_INSTR   = 4'd4;
    localparam logic [3:0] IDX_ADDR    = 4'd5;
    localparam logic [3:0] IDX_DATA    = 4'd6;

    localparam logic [7:0] LENGTH_BIAS = 8'd3;
    localparam logic [7:0] READ_COUNT  = 8'd2;

    typedef struct packed {
        logic [7:0]      header;
        logic [7:0]      id;
        logic [7:0]      length;
        logic [7:0]      instr;
        logic [7:0]      addr;
        logic [3:0][7:0] data;
        logic [3:0]      last_idx;
    } desc_t;

    typedef struct packed {
        logic [3:0] idx;
        logic       mid_packet;
    } back_status_t;

endpackage

[hdl/servo_command_packet_framer.sv]
// Top level of the servo command packet framer: front end, descriptor queue, serializer.
// A request's first byte passes the descriptor queue, then the serializer's output register.
// Throughput: one byte per cycle while pop keeps the output register free; a packet holds
// 8, 9 or 11 bytes by request type, each sent through the single-byte output register.
// A two-entry descriptor queue lets one further request be taken while a packet drains.
// Reset clears the queue, the serializer and the configuration registers to their defaults.
module servo_command_packet_framer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [2:0]                     cfg_index,
    input  logic [scpf_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     opcode,
    input  logic [7:0]                     servo_id,
    input  logic signed [15:0]             target_position,
    input  logic [15:0]                    move_time,
    input  logic                           torque_on,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     tx_byte,
    output logic                           last_byte
);

    scpf_pkg::desc_t        front_desc;
    logic                   front_valid;
    logic                   q_push;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    scpf_pkg::desc_t        q_head;
    scpf_pkg::back_status_t bstat;

    assign full   = q_full;
    assign q_push = push && !q_full && front_valid;

    scpf_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .servo_id        (servo_id),
        .target_position (target_position),
        .move_time       (move_time),
        .torque_on       (torque_on),
        .desc_valid      (front_valid),
        .desc            (front_desc)
    );

    scpf_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_desc (front_desc),
        .full    (q_full),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .rd_desc (q_head)
    );

    scpf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_desc    (q_head),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .tx_byte   (tx_byte),
        .last_byte (last_byte),
        .status    (bstat)
    );

    // The byte position never runs past the checksum of the packet being sent.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (bstat.idx <= q_head.last_idx))
        else $error("byte position beyond checksum");

    // A packet in progress keeps its descriptor at the head of the queue.
    a_mid_has_desc: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.mid_packet |-> !q_empty)
        else $error("packet in progress without descriptor");

    // Retiring a descriptor leaves its checksum byte waiting on the result ports.
    a_retire_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (!empty && last_byte))
        else $error("descriptor retired without checksum byte");

endmodule

[hdl/scpf_front.sv]
// Front end: configuration registers and request classification into a packet descriptor.
module scpf_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [2:0]                     cfg_index,
    input  logic [scpf_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic [1:0]                     opcode,
    input  logic [7:0]                     servo_id,
    input  logic signed [15:0]             target_position,
    input  logic [15:0]                    move_time,
    input  logic                           torque_on,
    output logic                           desc_valid,
    output scpf_pkg::desc_t                desc
);

    logic [7:0]  header_value_reg;
    logic [7:0]  write_instr_reg;
    logic [7:0]  read_instr_reg;
    logic [7:0]  goal_pos_addr_reg;
    logic [7:0]  present_pos_addr_reg;
    logic [7:0]  torque_addr_reg;
    logic [14:0] position_limit_reg;

    logic [14:0] pos_floor;
    logic [14:0] pos_clamped;
    logic [2:0]  ndata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg     <= 8'd255;
            write_instr_reg      <= 8'd3;
            read_instr_reg       <= 8'd2;
            goal_pos_addr_reg    <= 8'd42;
            present_pos_addr_reg <= 8'd56;
            torque_addr_reg      <= 8'd40;
            position_limit_reg   <= 15'd1023;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                scpf_pkg::REG_HEADER_VALUE:     header_value_reg     <= cfg_data[7:0];
                scpf_pkg::REG_WRITE_INSTR:      write_instr_reg      <= cfg_data[7:0];
                scpf_pkg::REG_READ_INSTR:       read_instr_reg       <= cfg_data[7:0];
                scpf_pkg::REG_GOAL_POSITION:    goal_pos_addr_reg    <= cfg_data[7:0];
                scpf_pkg::REG_PRESENT_POSITION: present_pos_addr_reg <= cfg_data[7:0];
                scpf_pkg::REG_TORQUE_ENABLE:    torque_addr_reg      <= cfg_data[7:0];
                scpf_pkg::REG_POSITION_LIMIT:   position_limit_reg   <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pos_floor   = target_position[15] ? 15'd0 : target_position[14:0];
        pos_clamped = (pos_floor > position_limit_reg) ? position_limit_reg : pos_floor;

        desc_valid  = 1'b1;
        desc.header = header_value_reg;
        desc.id     = servo_id;
        desc.instr  = write_instr_reg;
        desc.addr   = goal_pos_addr_reg;
        desc.data   = '0;
        ndata       = 3'd1;

        unique case (opcode)
            scpf_pkg::OP_GOAL_POS:
            begin
                desc.data[0] = {1'b0, pos_clamped[14:8]};
                desc.data[1] = pos_clamped[7:0];
                desc.data[2] = move_time[15:8];
                desc.data[3] = move_time[7:0];
                ndata        = (move_time != 16'd0) ? 3'd4 : 3'd2;
            end
            scpf_pkg::OP_TORQUE:
            begin
                desc.addr    = torque_addr_reg;
                desc.data[0] = {7'd0, torque_on};
            end
            scpf_pkg::OP_READ_POS:
            begin
                desc.instr   = read_instr_reg;
                desc.addr    = present_pos_addr_reg;
                desc.data[0] = scpf_pkg::READ_COUNT;
            end
            default:
            begin
                desc_valid = 1'b0;
            end
        endcase

        desc.length   = {5'd0, ndata} + scpf_pkg::LENGTH_BIAS;
        desc.last_idx = scpf_pkg::IDX_DATA + {1'b0, ndata};
    end

endmodule

[hdl/scpf_queue.sv]
// Two-entry descriptor queue between the front end and the byte serializer.
module scpf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  scpf_pkg::desc_t wr_desc,
    output logic            full,
    input  logic            rd_en,
    output logic            empty,
    output scpf_pkg::desc_t rd_desc
);

    scpf_pkg::desc_t entries [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_desc = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/scpf_back.sv]
// Back end: serializes one descriptor into packet bytes with a running checksum.
module scpf_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  scpf_pkg::desc_t        q_desc,
    output logic                   q_pop,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             tx_byte,
    output logic                   last_byte,
    output scpf_pkg::back_status_t status
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       advance;
    logic       at_last;
    logic [3:0] data_off;
    logic [7:0] cur_byte;

    always_comb
    begin
        advance  = !q_empty && (!out_valid_reg || pop);
        at_last  = (idx_reg == q_desc.last_idx);
        data_off = idx_reg - scpf_pkg::IDX_DATA;

        case (idx_reg)
            scpf_pkg::IDX_HEADER0: cur_byte = q_desc.header;
            scpf_pkg::IDX_HEADER1: cur_byte = q_desc.header;
            scpf_pkg::IDX_ID:      cur_byte = q_desc.id;
            scpf_pkg::IDX_LENGTH:  cur_byte = q_desc.length;
            scpf_pkg::IDX_INSTR:   cur_byte = q_desc.instr;
            scpf_pkg::IDX_ADDR:    cur_byte = q_desc.addr;
            default:               cur_byte = at_last ? ~sum_reg : q_desc.data[data_off[1:0]];
        endcase

        idx_next = idx_reg;
        sum_next = sum_reg;
        if (advance)
        begin
            if (at_last)
            begin
                idx_next = '0;
                sum_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
                sum_next = (idx_reg >= scpf_pkg::IDX_ID) ? sum_reg + cur_byte : sum_reg;
            end
        end

        out_valid_next = advance || (out_valid_reg && !pop);
        q_pop          = advance && at_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= at_last;
        end
    end

    assign empty             = !out_valid_reg;
    assign tx_byte           = out_byte_reg;
    assign last_byte         = out_last_reg;
    assign status.idx        = idx_reg;
    assign status.mid_packet = (idx_reg != 4'd0);

endmodule
